@@ hdl/tetra_mesh_neighbor_index_defines.svh @@
// ============================================================================
// Tetra mesh neighbor index: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ============================================================================
`ifndef TETRA_MESH_NEIGHBOR_INDEX_DEFINES_SVH
`define TETRA_MESH_NEIGHBOR_INDEX_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TMNI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define TMNI_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hdl/tmni_pkg.sv @@
// ============================================================================
// Tetra mesh neighbor index package
// Widths, register codes and the fixed neighbor offset table.
// ============================================================================
`timescale 1ns / 1ps

package tmni_pkg;

    localparam int MAX_CELLS_PER_AXIS = 256;
    localparam int NODES_PER_CELL     = 8;
    localparam int PORT_COUNT         = 4;
    localparam int PORT_W             = $clog2(PORT_COUNT);

    localparam int IDX_W     = 27;
    localparam int KIND_W    = $clog2(NODES_PER_CELL);
    localparam int CELL_W    = IDX_W - KIND_W;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 28;
    localparam int OFS_W     = 2;

    // Quotient bits resolved by one divider pipeline stage.
    localparam int STEPS_PER_STAGE = 4;

    // Largest linear index that can be reported.
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_X = 2'd0,
        REG_GRID_Y = 2'd1,
        REG_GRID_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic signed [OFS_W-1:0] dz;
        logic [KIND_W-1:0]       kind;
    } nb_offset_t;

    function automatic nb_offset_t nb_make(input int dx, input int dy, input int dz,
                                           input int kind);
        nb_offset_t e;
        e.dx   = OFS_W'(dx);
        e.dy   = OFS_W'(dy);
        e.dz   = OFS_W'(dz);
        e.kind = KIND_W'(kind);
        return e;
    endfunction

    // Cell offset and target node kind for each node kind and port.
    function automatic nb_offset_t nb_lookup(input logic [KIND_W-1:0] kind,
                                             input logic [PORT_W-1:0] port);
        nb_offset_t e;
        unique case ({kind, port})
            5'b000_00: e = nb_make( 0,  0,  0, 2);
            5'b000_01: e = nb_make(-1,  0, -1, 3);
            5'b000_10: e = nb_make( 0, -1, -1, 6);
            5'b000_11: e = nb_make(-1, -1,  0, 7);
            5'b001_00: e = nb_make( 0,  0,  0, 2);
            5'b001_01: e = nb_make( 0,  0,  0, 3);
            5'b001_10: e = nb_make( 0, -1,  0, 6);
            5'b001_11: e = nb_make( 0, -1,  0, 7);
            5'b010_00: e = nb_make( 0,  0,  0, 0);
            5'b010_01: e = nb_make( 0,  0,  0, 1);
            5'b010_10: e = nb_make( 0,  0,  0, 4);
            5'b010_11: e = nb_make( 0,  0,  0, 5);
            5'b011_00: e = nb_make( 1,  0,  1, 0);
            5'b011_01: e = nb_make( 0,  0,  0, 1);
            5'b011_10: e = nb_make( 1,  0,  0, 4);
            5'b011_11: e = nb_make( 0,  0,  1, 5);
            5'b100_00: e = nb_make( 0,  0,  0, 2);
            5'b100_01: e = nb_make(-1,  0,  0, 3);
            5'b100_10: e = nb_make( 0,  0,  0, 6);
            5'b100_11: e = nb_make(-1,  0,  0, 7);
            5'b101_00: e = nb_make( 0,  0,  0, 2);
            5'b101_01: e = nb_make( 0,  0, -1, 3);
            5'b101_10: e = nb_make( 0,  0, -1, 6);
            5'b101_11: e = nb_make( 0,  0,  0, 7);
            5'b110_00: e = nb_make( 0,  1,  1, 0);
            5'b110_01: e = nb_make( 0,  1,  0, 1);
            5'b110_10: e = nb_make( 0,  0,  0, 4);
            5'b110_11: e = nb_make( 0,  0,  1, 5);
            5'b111_00: e = nb_make( 1,  1,  0, 0);
            5'b111_01: e = nb_make( 0,  1,  0, 1);
            5'b111_10: e = nb_make( 1,  0,  0, 4);
            5'b111_11: e = nb_make( 0,  0,  0, 5);
            default:   e = nb_make( 0,  0,  0, 0);
        endcase
        return e;
    endfunction

endpackage

@@ hdl/tmni_div_stage.sv @@
// ============================================================================
// Tetra mesh neighbor index: divider stage
// One registered stage of a restoring divider, a few quotient bits per stage.
// ============================================================================
`timescale 1ns / 1ps

module tmni_div_stage #(
    parameter int NUM_W  = 24,
    parameter int DEN_W  = 9,
    parameter int SIDE_W = 3,
    parameter int STEPS  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [NUM_W-1:0]  up_num,
    input  logic [NUM_W-1:0]  up_quo,
    input  logic [DEN_W-1:0]  up_rem,
    input  logic [SIDE_W-1:0] up_side,
    input  logic [DEN_W-1:0]  divisor,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [NUM_W-1:0]  dn_num,
    output logic [NUM_W-1:0]  dn_quo,
    output logic [DEN_W-1:0]  dn_rem,
    output logic [SIDE_W-1:0] dn_side
);

    logic              valid_reg;
    logic              load;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [SIDE_W-1:0] side_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Each step brings down one dividend bit and subtracts when it fits.
    always_comb
    begin
        logic [DEN_W:0] part;
        logic           qbit;
        num_next = up_num;
        quo_next = up_quo;
        rem_next = up_rem;
        for (int i = 0; i < STEPS; i++)
        begin
            part = {rem_next, num_next[NUM_W-1]};
            num_next = {num_next[NUM_W-2:0], 1'b0};
            if (part >= {1'b0, divisor})
            begin
                part = part - {1'b0, divisor};
                qbit = 1'b1;
            end
            else
            begin
                qbit = 1'b0;
            end
            rem_next = part[DEN_W-1:0];
            quo_next = {quo_next[NUM_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_num   = num_reg;
    assign dn_quo   = quo_reg;
    assign dn_rem   = rem_reg;
    assign dn_side  = side_reg;

endmodule

@@ hdl/tmni_divider.sv @@
// ============================================================================
// Tetra mesh neighbor index: pipelined divider
// A chain of divider stages giving quotient and remainder, with side data.
// ============================================================================
`timescale 1ns / 1ps

module tmni_divider #(
    parameter int DIV_W  = 24,
    parameter int DEN_W  = 9,
    parameter int SIDE_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DIV_W-1:0]  in_num,
    input  logic [SIDE_W-1:0] in_side,
    input  logic [DEN_W-1:0]  divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DIV_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STEPS  = tmni_pkg::STEPS_PER_STAGE;
    localparam int STAGES = (DIV_W + STEPS - 1) / STEPS;
    localparam int PAD_W  = STAGES * STEPS;

    logic              valid_s [STAGES+1];
    logic              ready_s [STAGES+1];
    logic [PAD_W-1:0]  num_s   [STAGES+1];
    logic [PAD_W-1:0]  quo_s   [STAGES+1];
    logic [DEN_W-1:0]  rem_s   [STAGES+1];
    logic [SIDE_W-1:0] side_s  [STAGES+1];

    // Leading zero padding only adds zero quotient bits.
    assign valid_s[0] = in_valid;
    assign in_ready   = ready_s[0];
    assign num_s[0]   = PAD_W'(in_num);
    assign quo_s[0]   = '0;
    assign rem_s[0]   = '0;
    assign side_s[0]  = in_side;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        tmni_div_stage #(
            .NUM_W  (PAD_W),
            .DEN_W  (DEN_W),
            .SIDE_W (SIDE_W),
            .STEPS  (STEPS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_s[s]),
            .up_ready (ready_s[s]),
            .up_num   (num_s[s]),
            .up_quo   (quo_s[s]),
            .up_rem   (rem_s[s]),
            .up_side  (side_s[s]),
            .divisor  (divisor),
            .dn_valid (valid_s[s+1]),
            .dn_ready (ready_s[s+1]),
            .dn_num   (num_s[s+1]),
            .dn_quo   (quo_s[s+1]),
            .dn_rem   (rem_s[s+1]),
            .dn_side  (side_s[s+1])
        );
    end

    assign ready_s[STAGES] = out_ready;
    assign out_valid       = valid_s[STAGES];
    assign out_quo         = quo_s[STAGES][DIV_W-1:0];
    assign out_rem         = rem_s[STAGES];
    assign out_side        = side_s[STAGES];

endmodule

@@ hdl/tmni_neighbor.sv @@
// ============================================================================
// Tetra mesh neighbor index: neighbor recomposition
// Applies the offset table, checks bounds and rebuilds four linear indexes.
// ============================================================================
`timescale 1ns / 1ps

module tmni_neighbor #(
    parameter int EDW = 9
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [tmni_pkg::KIND_W-1:0]                   in_kind,
    input  logic [EDW-1:0]                                in_x,
    input  logic [EDW-1:0]                                in_y,
    input  logic [EDW-1:0]                                in_z,
    input  logic [EDW-1:0]                                dim_x,
    input  logic [EDW-1:0]                                dim_y,
    input  logic [EDW-1:0]                                dim_z,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [tmni_pkg::PORT_COUNT-1:0][tmni_pkg::OUT_W-1:0] out_nb
);

    localparam int PC     = tmni_pkg::PORT_COUNT;
    localparam int KW     = tmni_pkg::KIND_W;
    localparam int OW     = tmni_pkg::OUT_W;
    localparam int SW     = EDW + 2;
    localparam int T1_W   = 2 * EDW;
    localparam int T2_W   = 3 * EDW;
    localparam int LINR_W = T2_W + KW;
    localparam int LIN_W  = (LINR_W > OW) ? LINR_W : OW;

    logic [3:0] valid_reg;
    logic [3:0] rdy;
    logic [3:0] load;

    // Stage 1: offset cell coordinates and the bounds check.
    logic [PC-1:0]          s1_inb_reg,  s1_inb_next;
    logic [PC-1:0][EDW-1:0] s1_x_reg,    s1_x_next;
    logic [PC-1:0][EDW-1:0] s1_y_reg,    s1_y_next;
    logic [PC-1:0][EDW-1:0] s1_z_reg,    s1_z_next;
    logic [PC-1:0][KW-1:0]  s1_kind_reg, s1_kind_next;
    // Stage 2: y + ny * z.
    logic [PC-1:0]          s2_inb_reg;
    logic [PC-1:0][EDW-1:0] s2_x_reg;
    logic [PC-1:0][T1_W-1:0] s2_t1_reg,  s2_t1_next;
    logic [PC-1:0][KW-1:0]  s2_kind_reg;
    // Stage 3: x + nx * (y + ny * z).
    logic [PC-1:0]          s3_inb_reg;
    logic [PC-1:0][T2_W-1:0] s3_t2_reg,  s3_t2_next;
    logic [PC-1:0][KW-1:0]  s3_kind_reg;
    // Stage 4: final index or all ones.
    logic [PC-1:0][OW-1:0]  nb_reg,      nb_next;

    assign rdy[3]   = !valid_reg[3] || out_ready;
    assign rdy[2]   = !valid_reg[2] || rdy[3];
    assign rdy[1]   = !valid_reg[1] || rdy[2];
    assign rdy[0]   = !valid_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    assign load[0] = in_valid && rdy[0];
    assign load[1] = valid_reg[0] && rdy[1];
    assign load[2] = valid_reg[1] && rdy[2];
    assign load[3] = valid_reg[2] && rdy[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (rdy[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    always_comb
    begin
        tmni_pkg::nb_offset_t e;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] sz;
        for (int p = 0; p < PC; p++)
        begin
            e  = tmni_pkg::nb_lookup(in_kind, tmni_pkg::PORT_W'(p));
            sx = $signed({2'b00, in_x}) + SW'(e.dx);
            sy = $signed({2'b00, in_y}) + SW'(e.dy);
            sz = $signed({2'b00, in_z}) + SW'(e.dz);
            s1_inb_next[p] = (sx >= 0) && (sx < $signed({2'b00, dim_x})) &&
                             (sy >= 0) && (sy < $signed({2'b00, dim_y})) &&
                             (sz >= 0) && (sz < $signed({2'b00, dim_z}));
            s1_x_next[p]    = sx[EDW-1:0];
            s1_y_next[p]    = sy[EDW-1:0];
            s1_z_next[p]    = sz[EDW-1:0];
            s1_kind_next[p] = e.kind;
        end
    end

    always_comb
    begin
        for (int p = 0; p < PC; p++)
        begin
            s2_t1_next[p] = T1_W'(s1_y_reg[p]) + T1_W'(dim_y) * T1_W'(s1_z_reg[p]);
            s3_t2_next[p] = T2_W'(s2_x_reg[p]) + T2_W'(dim_x) * T2_W'(s2_t1_reg[p]);
        end
    end

    // An in-grid neighbor whose index does not fit the index range reads as -1.
    always_comb
    begin
        logic [LIN_W-1:0] lin;
        for (int p = 0; p < PC; p++)
        begin
            lin = LIN_W'({s3_t2_reg[p], s3_kind_reg[p]});
            if (s3_inb_reg[p] && (lin <= LIN_W'(tmni_pkg::IDX_MAX)))
            begin
                nb_next[p] = OW'(lin);
            end
            else
            begin
                nb_next[p] = '1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_inb_reg  <= s1_inb_next;
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s1_z_reg    <= s1_z_next;
            s1_kind_reg <= s1_kind_next;
        end
        if (load[1])
        begin
            s2_inb_reg  <= s1_inb_reg;
            s2_x_reg    <= s1_x_reg;
            s2_t1_reg   <= s2_t1_next;
            s2_kind_reg <= s1_kind_reg;
        end
        if (load[2])
        begin
            s3_inb_reg  <= s2_inb_reg;
            s3_t2_reg   <= s3_t2_next;
            s3_kind_reg <= s2_kind_reg;
        end
        if (load[3])
        begin
            nb_reg <= nb_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_nb    = nb_reg;

endmodule

@@ hdl/tetra_mesh_neighbor_index.sv @@
// ============================================================================
// Tetra mesh neighbor index
// Splits a linear tetrahedral mesh node index into node kind and cell
// coordinates, and returns the linear indexes of the node's four neighbors.
// ============================================================================
//
//  Channel  | Signals                                     | Direction
//  ---------+---------------------------------------------+----------
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//  input    | in_valid, in_ready, node_index              | in
//  output   | out_valid, out_ready, neighbor_a..neighbor_d| out
//
//  One node index is taken per cycle and one result leaves per cycle while
//  the output is not stalled. Three pipelined dividers resolve four quotient
//  bits per stage, then four recomposition stages follow.
//  Reset clears every valid bit and sets all three grid dimensions to one.
//  A stalled output fills the pipeline's empty stages first; input ready
//  drops only when every stage holds an item.
//
`timescale 1ns / 1ps
`include "tetra_mesh_neighbor_index_defines.svh"

module tetra_mesh_neighbor_index #(
    parameter int MAX_CELLS_PER_AXIS = tmni_pkg::MAX_CELLS_PER_AXIS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tmni_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmni_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [tmni_pkg::IDX_W-1:0]         node_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [tmni_pkg::OUT_W-1:0]  neighbor_a,
    output logic signed [tmni_pkg::OUT_W-1:0]  neighbor_b,
    output logic signed [tmni_pkg::OUT_W-1:0]  neighbor_c,
    output logic signed [tmni_pkg::OUT_W-1:0]  neighbor_d
);

    // Width of an effective grid dimension: the register is clamped to the
    // per-axis maximum, so it never needs more bits than that maximum.
    localparam int DIM_CLOG = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int EDW      = (DIM_CLOG < tmni_pkg::CFG_W) ? DIM_CLOG : tmni_pkg::CFG_W;
    localparam int KW       = tmni_pkg::KIND_W;
    localparam int CW       = tmni_pkg::CELL_W;
    localparam int PC       = tmni_pkg::PORT_COUNT;
    localparam int OW       = tmni_pkg::OUT_W;

    // ------------------------------------------------------------------
    // Configuration. The stored values are already clamped to the maximum.
    // A write to an index past the register list is taken and dropped.
    // ------------------------------------------------------------------
    logic           cfg_write;
    logic [EDW-1:0] cfg_clamped;
    logic [EDW-1:0] grid_x_reg, grid_x_next;
    logic [EDW-1:0] grid_y_reg, grid_y_next;
    logic [EDW-1:0] grid_z_reg, grid_z_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (int'(cfg_data) > MAX_CELLS_PER_AXIS)
        begin
            cfg_clamped = EDW'(MAX_CELLS_PER_AXIS);
        end
        else
        begin
            cfg_clamped = EDW'(cfg_data);
        end
    end

    always_comb
    begin
        grid_x_next = grid_x_reg;
        grid_y_next = grid_y_reg;
        grid_z_next = grid_z_reg;
        if (cfg_write)
        begin
            unique case (tmni_pkg::cfg_reg_t'(cfg_index))
                tmni_pkg::REG_GRID_X: grid_x_next = cfg_clamped;
                tmni_pkg::REG_GRID_Y: grid_y_next = cfg_clamped;
                tmni_pkg::REG_GRID_Z: grid_z_next = cfg_clamped;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= EDW'(1);
            grid_y_reg <= EDW'(1);
            grid_z_reg <= EDW'(1);
        end
        else
        begin
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
            grid_z_reg <= grid_z_next;
        end
    end

    // A zero dimension divides as one. Its bounds check still uses zero, so
    // every neighbor of such a grid comes out as -1.
    logic [EDW-1:0] div_x;
    logic [EDW-1:0] div_y;
    logic [EDW-1:0] div_z;

    assign div_x = (grid_x_reg == '0) ? EDW'(1) : grid_x_reg;
    assign div_y = (grid_y_reg == '0) ? EDW'(1) : grid_y_reg;
    assign div_z = (grid_z_reg == '0) ? EDW'(1) : grid_z_reg;

    // ------------------------------------------------------------------
    // Coordinate split. The low bits of the index are the node kind; the
    // cell number is divided by nx, the quotient by ny, and the second
    // quotient is reduced modulo nz to give z. The kind and the coordinates
    // found so far ride along each divider as side data.
    // ------------------------------------------------------------------
    logic              d1_valid, d1_ready;
    logic [CW-1:0]     d1_quo;
    logic [EDW-1:0]    d1_rem;
    logic [KW-1:0]     d1_side;

    logic              d2_valid, d2_ready;
    logic [CW-1:0]     d2_quo;
    logic [EDW-1:0]    d2_rem;
    logic [KW+EDW-1:0] d2_side;

    logic                d3_valid, d3_ready;
    logic [EDW-1:0]      d3_rem;
    logic [KW+2*EDW-1:0] d3_side;

    tmni_divider #(
        .DIV_W  (CW),
        .DEN_W  (EDW),
        .SIDE_W (KW)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_num    (node_index[tmni_pkg::IDX_W-1:KW]),
        .in_side   (node_index[KW-1:0]),
        .divisor   (div_x),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  (d1_side)
    );

    tmni_divider #(
        .DIV_W  (CW),
        .DEN_W  (EDW),
        .SIDE_W (KW + EDW)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_num    (d1_quo),
        .in_side   ({d1_side, d1_rem}),
        .divisor   (div_y),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_side  (d2_side)
    );

    // Only the remainder of the z division is needed: it wraps the layer.
    tmni_divider #(
        .DIV_W  (CW),
        .DEN_W  (EDW),
        .SIDE_W (KW + 2 * EDW)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .in_num    (d2_quo),
        .in_side   ({d2_side, d2_rem}),
        .divisor   (div_z),
        .out_valid (d3_valid),
        .out_ready (d3_ready),
        .out_quo   (),
        .out_rem   (d3_rem),
        .out_side  (d3_side)
    );

    // ------------------------------------------------------------------
    // Neighbor offsets, bounds checks and recomposition; its last stage is
    // the output register.
    // ------------------------------------------------------------------
    logic [PC-1:0][OW-1:0] nb_out;

    tmni_neighbor #(
        .EDW (EDW)
    ) u_neighbor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d3_valid),
        .in_ready  (d3_ready),
        .in_kind   (d3_side[KW+2*EDW-1:2*EDW]),
        .in_x      (d3_side[2*EDW-1:EDW]),
        .in_y      (d3_side[EDW-1:0]),
        .in_z      (d3_rem),
        .dim_x     (grid_x_reg),
        .dim_y     (grid_y_reg),
        .dim_z     (grid_z_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_nb    (nb_out)
    );

    assign neighbor_a = $signed(nb_out[0]);
    assign neighbor_b = $signed(nb_out[1]);
    assign neighbor_c = $signed(nb_out[2]);
    assign neighbor_d = $signed(nb_out[3]);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Each port only ever targets two node kinds: port 0 kinds 0 and 2,
    // port 1 kinds 1 and 3, port 2 kinds 4 and 6, port 3 kinds 5 and 7.
    logic port_kinds_ok;

    assign port_kinds_ok =
        ((&neighbor_a) || (!neighbor_a[0] && !neighbor_a[2])) &&
        ((&neighbor_b) || ( neighbor_b[0] && !neighbor_b[2])) &&
        ((&neighbor_c) || (!neighbor_c[0] &&  neighbor_c[2])) &&
        ((&neighbor_d) || ( neighbor_d[0] &&  neighbor_d[2]));

    `TMNI_ASSERT(a_port_kinds, (out_valid |-> port_kinds_ok), "neighbor targets wrong node kind")
    `TMNI_ASSERT(a_ready_chain, (out_ready |-> in_ready), "input stalled while output drains")
    `TMNI_NEVER(a_full_only, (!in_ready && !out_valid), "input stalled with empty output stage")

endmodule
